>>> rtl/core/search_bound_memo_table_assert.svh
// Assertion macros used by the search bound memo table RTL.
// Each macro expects clk and rst_n to be visible in the calling module.
`ifndef SEARCH_BOUND_MEMO_TABLE_ASSERT_SVH
`define SEARCH_BOUND_MEMO_TABLE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define SBMT_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset
`define SBMT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/sbmt_pkg.sv
package sbmt_pkg;

    // Table geometry; entry count must be a power of two
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = $clog2(TABLE_ENTRIES);
    localparam int KEY_W         = 64;
    localparam int BUDGET_W      = 10;
    localparam int BOUND_W       = 11;

    localparam logic [63:0] HASH_MIX = 64'h9e3779b97f4a7c15;

    typedef enum logic [1:0] {
        OP_PRUNE  = 2'd0,
        OP_RECORD = 2'd1,
        OP_BUDGET = 2'd2,
        OP_CLEAR  = 2'd3
    } op_t;

    typedef struct packed {
        op_t                 op;
        logic [KEY_W-1:0]    key_high;
        logic [KEY_W-1:0]    key_low;
        logic [BUDGET_W-1:0] budget;
        logic                outcome;
    } req_word_t;

    typedef struct packed {
        logic               found;
        logic               decided;
        logic               decided_value;
        logic [BOUND_W-1:0] required_budget;
    } rsp_word_t;

    // One table slot; bounds are two's complement, all ones meaning unknown
    typedef struct packed {
        logic [KEY_W-1:0]   key_high;
        logic [KEY_W-1:0]   key_low;
        logic [BOUND_W-1:0] least_success;
        logic [BOUND_W-1:0] greatest_fail;
    } entry_t;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic commit;
    } cmd_t;

    // Slot index: low bits of hi ^ (lo + mix + (hi << 6) + (hi >> 2)).
    // Carries only run upward, so the low bits of the sum need low bits only.
    function automatic logic [IDX_W-1:0] slot_of(input logic [KEY_W-1:0] hi,
                                                 input logic [KEY_W-1:0] lo);
        logic [KEY_W-1:0] shl;
        logic [IDX_W-1:0] sum;
        shl = hi << 6;
        sum = lo[IDX_W-1:0] + HASH_MIX[IDX_W-1:0] + shl[IDX_W-1:0] + hi[IDX_W+1:2];
        return hi[IDX_W-1:0] ^ sum;
    endfunction

endpackage

>>> rtl/core/search_bound_memo_table.sv
// Direct-mapped memo of search bounds keyed by a 128-bit key.
// Request channel (req_valid/req_ready/req_data): one word per operation:
// prune query, record outcome, budget query or clear all.
// Response channel (rsp_valid/rsp_ready/rsp_data): exactly one word per
// request, in request order.
// Response: an accepted request waits in the lookup stage and commits once
// the response register is free; the commit raises rsp_valid, held until taken.
// Requests go one at a time through the single table port: a new one is
// accepted only after the current one commits. The accept edge reads the
// slot; at commit the key is compared, the bounds updated and the slot written.
// A clear drops all slot valid bits at its commit.
// Reset: all slot valid bits and the control state clear at once; no
// clearing pass, requests are taken from the first cycle after reset.
// Receiver stall: a pending response holds; the next request is still
// accepted and waits in the lookup stage until the response is taken.
module search_bound_memo_table
    import sbmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      req_valid,
    output logic      req_ready,
    input  req_word_t req_data,
    output logic      rsp_valid,
    input  logic      rsp_ready,
    output rsp_word_t rsp_data
);

    cmd_t cmd;

    sbmt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    sbmt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req_data (req_data),
        .rsp_data (rsp_data)
    );

endmodule

>>> rtl/core/sbmt_datapath.sv
module sbmt_datapath
    import sbmt_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cmd_t      cmd,
    input  req_word_t req_data,
    output rsp_word_t rsp_data
);

    // Slot storage and per-slot valid bits
    entry_t                   mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] slot_valid_reg;

    // Captured request
    op_t                 op_reg;
    logic [KEY_W-1:0]    key_high_reg;
    logic [KEY_W-1:0]    key_low_reg;
    logic [BUDGET_W-1:0] budget_reg;
    logic                outcome_reg;
    logic [IDX_W-1:0]    idx_reg;

    // Registered read of the addressed slot
    entry_t rd_entry_reg;
    logic   rd_valid_reg;

    rsp_word_t rsp_reg;
    rsp_word_t rsp_next;

    logic [IDX_W-1:0]   req_idx;
    logic               hit;
    logic signed [11:0] k_s;
    logic signed [11:0] km1_s;
    logic signed [11:0] ls_cur;
    logic signed [11:0] gf_cur;
    logic signed [11:0] ls_new;
    logic signed [11:0] gf_new;
    logic signed [11:0] gf_lim;
    logic signed [11:0] req_sum;
    entry_t             wr_entry;

    assign req_idx = slot_of(req_data.key_high, req_data.key_low);

    // Capture the word, read the slot, write back a record, register the response
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= req_data.op;
            key_high_reg <= req_data.key_high;
            key_low_reg  <= req_data.key_low;
            budget_reg   <= req_data.budget;
            outcome_reg  <= req_data.outcome;
            idx_reg      <= req_idx;
            rd_entry_reg <= mem[req_idx];
        end
        if (cmd.commit && op_reg == OP_RECORD)
        begin
            mem[idx_reg] <= wr_entry;
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    // Valid bits: set on record, drop all on clear
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.capture)
            begin
                rd_valid_reg <= slot_valid_reg[req_idx];
            end
            if (cmd.commit && op_reg == OP_CLEAR)
            begin
                slot_valid_reg <= '0;
            end
            else if (cmd.commit && op_reg == OP_RECORD)
            begin
                slot_valid_reg[idx_reg] <= 1'b1;
            end
        end
    end

    // Compare key and bring the bounds to 12-bit signed
    always_comb
    begin
        hit    = rd_valid_reg && (rd_entry_reg.key_high == key_high_reg)
                 && (rd_entry_reg.key_low == key_low_reg);
        k_s    = signed'({2'b00, budget_reg});
        km1_s  = k_s - 12'sd1;
        ls_cur = hit ? signed'({rd_entry_reg.least_success[BOUND_W-1],
                                rd_entry_reg.least_success}) : -12'sd1;
        gf_cur = hit ? signed'({rd_entry_reg.greatest_fail[BOUND_W-1],
                                rd_entry_reg.greatest_fail}) : -12'sd1;
    end

    // Tighten bounds for a record
    always_comb
    begin
        ls_new = ls_cur;
        gf_new = gf_cur;
        gf_lim = gf_cur;
        if (outcome_reg)
        begin
            if (ls_cur < 0 || k_s < ls_cur)
            begin
                ls_new = k_s;
            end
            if (km1_s < gf_cur)
            begin
                gf_lim = km1_s;
            end
            gf_new = (gf_lim >= ls_new) ? (ls_new - 12'sd1) : gf_lim;
        end
        else if (k_s > gf_cur)
        begin
            gf_new = k_s;
        end
        wr_entry.key_high      = key_high_reg;
        wr_entry.key_low       = key_low_reg;
        wr_entry.least_success = ls_new[BOUND_W-1:0];
        wr_entry.greatest_fail = gf_new[BOUND_W-1:0];
    end

    // Form the response word
    always_comb
    begin
        rsp_next = '0;
        req_sum  = gf_cur + 12'sd1;
        case (op_reg)
            OP_PRUNE:
            begin
                rsp_next.found = hit;
                if (hit && ls_cur >= 0 && k_s >= ls_cur)
                begin
                    rsp_next.decided       = 1'b1;
                    rsp_next.decided_value = 1'b1;
                end
                else if (hit && k_s <= gf_cur)
                begin
                    rsp_next.decided = 1'b1;
                end
            end
            OP_RECORD:
            begin
                rsp_next.found = hit;
            end
            OP_BUDGET:
            begin
                rsp_next.found = hit;
                if (hit && req_sum > 0)
                begin
                    rsp_next.required_budget = req_sum[BOUND_W-1:0];
                end
            end
            default:
            begin
                rsp_next = '0;
            end
        endcase
    end

    assign rsp_data = rsp_reg;

endmodule

>>> rtl/core/sbmt_ctrl.sv
module sbmt_ctrl
    import sbmt_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    output logic rsp_valid,
    input  logic rsp_ready,
    output cmd_t cmd
);

`include "search_bound_memo_table_assert.svh"

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_LOOK = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    // Issue commands: capture on accept, commit once the output slot is free
    always_comb
    begin
        req_ready   = (state_reg == S_IDLE);
        cmd.capture = req_valid && req_ready;
        cmd.commit  = (state_reg == S_LOOK) && (!rsp_valid_reg || rsp_ready);
    end

    // Advance the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.capture)
                begin
                    state_next = S_LOOK;
                end
            end
            S_LOOK:
            begin
                if (cmd.commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the response valid until taken
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.commit)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

    `SBMT_ASSERT_NEXT(a_accept_to_look, req_valid && req_ready, state_reg == S_LOOK,
        "accepted word did not move to lookup")
    `SBMT_ASSERT_NEXT(a_commit_shows, cmd.commit, rsp_valid_reg,
        "committed word not presented")
    `SBMT_ASSERT_NEXT(a_stall_holds, state_reg == S_LOOK && rsp_valid_reg && !rsp_ready,
        state_reg == S_LOOK && rsp_valid_reg, "stalled lookup released early")
    `SBMT_ASSERT_NOW(a_no_capture_busy, state_reg == S_LOOK, !cmd.capture,
        "capture while a lookup is pending")

endmodule
